FILE: src/ddp_frame_receive_checker_macros.svh
// Assertion macros for the DDP frame receive checker.
// Expects a clock named clk and a synchronous active-low reset named rst_n in scope.
`ifndef DDP_FRAME_RECEIVE_CHECKER_MACROS_SVH
`define DDP_FRAME_RECEIVE_CHECKER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DDPFRC_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ddpfrc: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define DDPFRC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ddpfrc: next-cycle check failed");

`endif

FILE: src/ddpfrc_pkg.sv
// Shared types and constants for the DDP frame receive checker.
// No dependencies; used by ddpfrc_hdr and ddp_frame_receive_checker.
`timescale 1ns / 1ps

package ddpfrc_pkg;

  // Frame geometry
  localparam int HDR_BYTES       = 12;
  localparam int SUM_START       = 4;
  localparam int MAX_FRAME_BYTES = 1024;
  localparam int COUNT_W         = 11;
  localparam logic [COUNT_W-1:0] COUNT_CAP = '1;
  localparam logic [7:0] BCAST_NODE = 8'hFF;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_MY_NET          = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MY_NODE         = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CHECKSUM_ENABLE = 2'd2;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [2:0] {
    DROP_NONE      = 3'd0,
    DROP_TOO_LONG  = 3'd1,
    DROP_TOO_SHORT = 3'd2,
    DROP_NOT_MINE  = 3'd3,
    DROP_TRUNCATED = 3'd4,
    DROP_BAD_LEN   = 3'd5,
    DROP_CHECKSUM  = 3'd6
  } drop_reason_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic         accepted;
    drop_reason_t drop_reason;
    logic [15:0]  source_net;
    logic [7:0]   source_node;
    logic [7:0]   source_port;
    logic [7:0]   dest_port;
    logic [9:0]   payload_length;
  } out_t;

  // Per-frame state captured from the byte stream
  typedef struct packed {
    logic [COUNT_W-1:0] byte_count;
    logic [15:0]        running_sum;
    logic [9:0]         header_length;
    logic [15:0]        received_sum;
    logic [15:0]        dest_net;
    logic [15:0]        src_net;
    logic [7:0]         dest_node;
    logic [7:0]         src_node;
    logic [7:0]         dest_port;
    logic [7:0]         src_port;
  } frame_t;

endpackage

FILE: src/ddpfrc_hdr.sv
// Header capture, byte counter and add-and-rotate checksum for one DDP frame.
// Depends on ddpfrc_pkg and ddp_frame_receive_checker_macros.svh.
`timescale 1ns / 1ps
`include "ddp_frame_receive_checker_macros.svh"

module ddpfrc_hdr (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              take,
  input  ddpfrc_pkg::in_t   in_item,
  output ddpfrc_pkg::frame_t frame_upd
);

  ddpfrc_pkg::frame_t frame_r;
  ddpfrc_pkg::frame_t frame_nxt;
  logic [ddpfrc_pkg::COUNT_W-1:0] idx;
  logic [7:0]  b;
  logic [15:0] sum_add;

  assign idx = frame_r.byte_count;
  assign b   = in_item.frame_byte;

  // Fold the current byte into the frame state
  always_comb begin
    frame_upd = frame_r;
    if (idx < ddpfrc_pkg::COUNT_W'(ddpfrc_pkg::HDR_BYTES)) begin
      case (idx[3:0])
        4'd0:    frame_upd.header_length[9:8] = b[1:0];
        4'd1:    frame_upd.header_length[7:0] = b;
        4'd2:    frame_upd.received_sum[15:8] = b;
        4'd3:    frame_upd.received_sum[7:0]  = b;
        4'd4:    frame_upd.dest_net[15:8]     = b;
        4'd5:    frame_upd.dest_net[7:0]      = b;
        4'd6:    frame_upd.src_net[15:8]      = b;
        4'd7:    frame_upd.src_net[7:0]       = b;
        4'd8:    frame_upd.dest_node          = b;
        4'd9:    frame_upd.src_node           = b;
        4'd10:   frame_upd.dest_port          = b;
        4'd11:   frame_upd.src_port           = b;
        default: ;
      endcase
    end
    // Add, then rotate left by one; padding past the length is skipped
    sum_add = frame_r.running_sum + {8'h00, b};
    if (idx >= ddpfrc_pkg::COUNT_W'(ddpfrc_pkg::SUM_START) &&
        idx < {1'b0, frame_upd.header_length}) begin
      frame_upd.running_sum = {sum_add[14:0], sum_add[15]};
    end
    // Saturate the byte counter
    if (idx != ddpfrc_pkg::COUNT_CAP) begin
      frame_upd.byte_count = idx + 1'b1;
    end
  end

  // Clear after the last byte of a frame
  always_comb begin
    frame_nxt = frame_r;
    if (take) begin
      frame_nxt = in_item.last_byte ? '0 : frame_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_r <= '0;
    end else begin
      frame_r <= frame_nxt;
    end
  end

  `DDPFRC_ASSERT_NEXT(a_clear_after_last, take && in_item.last_byte, frame_r.byte_count == '0)
  `DDPFRC_ASSERT_NEXT(a_count_moves, take && !in_item.last_byte, frame_r.byte_count != '0)

endmodule

FILE: src/ddp_frame_receive_checker.sv
// Output: one verdict, registered, valid in the cycle after the last byte of a frame is accepted.
// Throughput: one byte per cycle; the input stalls only while a verdict waits in
// the output register and out_ready is low, the single result register sets this.
// Reset: rst_n synchronous active low clears frame state and the output valid,
// and sets my_net 0, my_node 0, checksum_enable 1.
// Depends on ddpfrc_pkg, ddpfrc_hdr and ddp_frame_receive_checker_macros.svh.
`timescale 1ns / 1ps
`include "ddp_frame_receive_checker_macros.svh"

module ddp_frame_receive_checker #(
  parameter int MAX_FRAME_BYTES = ddpfrc_pkg::MAX_FRAME_BYTES
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  ddpfrc_pkg::in_t                      in_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output ddpfrc_pkg::out_t                     out_data,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [ddpfrc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ddpfrc_pkg::CFG_DATA_W-1:0]    cfg_data
);

  logic [15:0] my_net_r;
  logic [7:0]  my_node_r;
  logic        checksum_enable_r;

  logic              out_valid_r;
  ddpfrc_pkg::out_t  out_data_r;
  ddpfrc_pkg::out_t  result;
  ddpfrc_pkg::frame_t f;
  ddpfrc_pkg::drop_reason_t reason;
  logic        in_take;
  logic [15:0] computed;
  logic        out_reason_ok;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid_r || out_ready;
  assign in_take   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      my_net_r          <= '0;
      my_node_r         <= '0;
      checksum_enable_r <= 1'b1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        ddpfrc_pkg::CFG_MY_NET:          my_net_r          <= cfg_data[15:0];
        ddpfrc_pkg::CFG_MY_NODE:         my_node_r         <= cfg_data[7:0];
        ddpfrc_pkg::CFG_CHECKSUM_ENABLE: checksum_enable_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  ddpfrc_hdr u_hdr (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (in_take),
    .in_item   (in_data),
    .frame_upd (f)
  );

  // Pick the first failing check
  always_comb begin
    computed = (f.running_sum == '0) ? 16'hFFFF : f.running_sum;
    if (f.byte_count > ddpfrc_pkg::COUNT_W'(MAX_FRAME_BYTES)) begin
      reason = ddpfrc_pkg::DROP_TOO_LONG;
    end else if (f.byte_count < ddpfrc_pkg::COUNT_W'(ddpfrc_pkg::HDR_BYTES)) begin
      reason = ddpfrc_pkg::DROP_TOO_SHORT;
    end else if ((f.dest_node != my_node_r && f.dest_node != ddpfrc_pkg::BCAST_NODE) ||
                 (f.dest_net != '0 && f.dest_net != my_net_r)) begin
      reason = ddpfrc_pkg::DROP_NOT_MINE;
    end else if (f.byte_count < {1'b0, f.header_length}) begin
      reason = ddpfrc_pkg::DROP_TRUNCATED;
    end else if (f.header_length < 10'(ddpfrc_pkg::HDR_BYTES)) begin
      reason = ddpfrc_pkg::DROP_BAD_LEN;
    end else if (checksum_enable_r && f.received_sum != '0 && f.received_sum != computed) begin
      reason = ddpfrc_pkg::DROP_CHECKSUM;
    end else begin
      reason = ddpfrc_pkg::DROP_NONE;
    end

    result.accepted    = (reason == ddpfrc_pkg::DROP_NONE);
    result.drop_reason = reason;
    result.source_net  = f.src_net;
    result.source_node = f.src_node;
    result.source_port = f.src_port;
    result.dest_port   = f.dest_port;
    if (f.header_length >= 10'(ddpfrc_pkg::HDR_BYTES)) begin
      result.payload_length = f.header_length - 10'(ddpfrc_pkg::HDR_BYTES);
    end else begin
      result.payload_length = '0;
    end
  end

  // Hold the verdict until the downstream side takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_take && in_data.last_byte) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take && in_data.last_byte) begin
      out_data_r <= result;
    end
  end

  // Accepted flag agrees with the drop reason
  assign out_reason_ok = out_data_r.accepted ==
                         (out_data_r.drop_reason == ddpfrc_pkg::DROP_NONE);

  `DDPFRC_ASSERT_NEXT(a_last_gives_verdict, in_take && in_data.last_byte, out_valid_r)
  `DDPFRC_ASSERT_NEXT(a_no_verdict_midframe, in_take && !in_data.last_byte, !out_valid_r)
  `DDPFRC_ASSERT_SAME(a_accept_matches_reason, out_valid_r, out_reason_ok)
  `DDPFRC_ASSERT_SAME(a_payload_in_range, out_valid_r, out_data_r.payload_length <= 10'd1011)

endmodule
